/* rtl/ffba_pkg.sv */
// Shared types, codes and sizing constants of the first-fit block allocator.
// Used by every module of the block but ffba_ram; depends on nothing.
`timescale 1ns / 1ps

package ffba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 24;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int CSR_ADDR_W   = 3;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_ARRAY   = 2'd1;
   localparam logic [1:0] CMD_RESIZE  = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_ZERO    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_FREED   = 3'd4;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] request_size;
      logic [31:0] element_count;
      logic [31:0] element_bytes;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [2:0]  status;
      logic [31:0] copy_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] blk_start;
      logic [31:0] blk_size;
      logic        blk_free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [31:0] heap_base;
      logic [31:0] heap_limit;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

/* rtl/ffba_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; no package needed.
`timescale 1ns / 1ps

module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ffba_engine.sv */
// Command sequencer of the allocator: scans the block table held in one RAM,
// then updates it. Depends on ffba_pkg and ffba_ram.
`timescale 1ns / 1ps

module ffba_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_take,
   input  ffba_pkg::req_type     req,
   input  ffba_pkg::cfg_type     cfg,
   input  logic                  out_free,
   output ffba_pkg::eng_stat_type stat,
   output ffba_pkg::rsp_type     result
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL      = 3'd1;
   localparam logic [2:0] S_DECODE   = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_HIT      = 3'd4;
   localparam logic [2:0] S_APPEND   = 3'd5;
   localparam logic [2:0] S_FREE_OLD = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   localparam int IW = ffba_pkg::IDX_W;
   localparam int CW = ffba_pkg::CNT_W;

   logic [2:0]          state_ff, state_in;
   ffba_pkg::req_type   req_ff, req_in;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         size_ff, size_in;
   logic                grab_ff, grab_in;
   logic                resize_ff, resize_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [IW-1:0]       pend_idx_ff, pend_idx_in;
   ffba_pkg::entry_type hit_ff, hit_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic [IW-1:0]       old_idx_ff, old_idx_in;
   logic [31:0]         old_size_ff, old_size_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [32:0]         top_ff, top_in;
   ffba_pkg::rsp_type   res_ff, res_in;

   logic                     wr_en, rd_en;
   logic [IW-1:0]            wr_addr;
   ffba_pkg::entry_type      wr_entry, rd_entry;
   logic [ffba_pkg::ENTRY_W-1:0] rd_word;

   ffba_ram #(
      .WIDTH (ffba_pkg::ENTRY_W),
      .DEPTH (ffba_pkg::MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = ffba_pkg::entry_type'(rd_word);

   always_comb begin
      logic [33:0] need;
      logic [31:0] app_addr;
      logic        match;
      logic        more;
      logic [31:0] eff_size;
      logic        go_grab, go_lookup, zero_fail, over_fail;

      state_in    = state_ff;
      req_in      = req_ff;
      prod_in     = prod_ff;
      size_in     = size_ff;
      grab_in     = grab_ff;
      resize_in   = resize_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      old_idx_in  = old_idx_ff;
      old_size_in = old_size_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_entry    = '0;
      rd_en       = 1'b0;

      need = {1'b0, top_ff} + 34'(ffba_pkg::HEADER_BYTES) + {2'b00, size_ff};
      app_addr = cfg.heap_base + top_ff[31:0] + 32'(ffba_pkg::HEADER_BYTES);
      match = grab_ff ? (rd_entry.blk_free && (rd_entry.blk_size >= size_ff))
                      : (rd_entry.blk_start == req_ff.block_address);
      more = issue_ff < count_ff;

      eff_size  = req_ff.request_size;
      go_grab   = 1'b0;
      go_lookup = 1'b0;
      zero_fail = 1'b0;
      over_fail = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in   = req;
               res_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = {32'd0, req_ff.element_count} * {32'd0, req_ff.element_bytes};
            state_in = S_DECODE;
         end
         S_DECODE: begin
            case (req_ff.command)
               ffba_pkg::CMD_ARRAY: begin
                  eff_size = prod_ff[31:0];
                  if (prod_ff[63:32] != 32'd0) begin
                     over_fail = 1'b1;
                  end else if (prod_ff[31:0] == 32'd0) begin
                     zero_fail = 1'b1;
                  end else begin
                     go_grab = 1'b1;
                  end
               end
               ffba_pkg::CMD_ALLOC: begin
                  zero_fail = (eff_size == 32'd0);
                  go_grab   = !zero_fail;
               end
               ffba_pkg::CMD_RESIZE: begin
                  if (req_ff.block_address == 32'd0) begin
                     zero_fail = (eff_size == 32'd0);
                     go_grab   = !zero_fail;
                  end else begin
                     go_lookup = 1'b1;
                  end
               end
               default: begin
                  go_lookup = (req_ff.block_address != 32'd0);
               end
            endcase
            size_in   = eff_size;
            resize_in = go_lookup && (req_ff.command == ffba_pkg::CMD_RESIZE);
            grab_in   = go_grab;
            issue_in  = '0;
            pend_in   = 1'b0;
            if (over_fail) begin
               res_in.status = ffba_pkg::ST_NOSPACE;
            end else if (zero_fail) begin
               res_in.status = ffba_pkg::ST_ZERO;
            end
            state_in = (go_grab || go_lookup) ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            // Reads are issued one entry a cycle; the data of the previous
            // read is checked in the same cycle.
            if (more) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && match) begin
               hit_in     = rd_entry;
               hit_idx_in = pend_idx_ff;
               pend_in    = 1'b0;
               state_in   = S_HIT;
            end else if (!pend_ff && !more) begin
               if (grab_ff) begin
                  state_in = S_APPEND;
               end else begin
                  res_in.status = ffba_pkg::ST_UNKNOWN;
                  state_in      = S_RESP;
               end
            end
         end
         S_HIT: begin
            if (grab_ff) begin
               wr_en    = 1'b1;
               wr_addr  = hit_idx_ff;
               wr_entry = '{blk_start: hit_ff.blk_start, blk_size: hit_ff.blk_size,
                            blk_free: 1'b0};
               res_in.result_address = hit_ff.blk_start;
               if (resize_ff) begin
                  res_in.copy_length = old_size_ff;
                  state_in           = S_FREE_OLD;
               end else begin
                  state_in = S_RESP;
               end
            end else if (hit_ff.blk_free) begin
               res_in.status = ffba_pkg::ST_FREED;
               state_in      = S_RESP;
            end else if (req_ff.command == ffba_pkg::CMD_RELEASE) begin
               wr_en    = 1'b1;
               wr_addr  = hit_idx_ff;
               wr_entry = '{blk_start: hit_ff.blk_start, blk_size: hit_ff.blk_size,
                            blk_free: 1'b1};
               state_in = S_RESP;
            end else if (hit_ff.blk_size >= size_ff) begin
               res_in.result_address = req_ff.block_address;
               state_in              = S_RESP;
            end else begin
               // Block too small: look for a new one, old block stays busy.
               old_idx_in  = hit_idx_ff;
               old_size_in = hit_ff.blk_size;
               grab_in     = 1'b1;
               issue_in    = '0;
               pend_in     = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_APPEND: begin
            if ((count_ff == CW'(ffba_pkg::MAX_BLOCKS)) ||
                (need > {2'b00, cfg.heap_limit})) begin
               res_in.status = ffba_pkg::ST_NOSPACE;
               state_in      = S_RESP;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               wr_entry = '{blk_start: app_addr, blk_size: size_ff, blk_free: 1'b0};
               count_in = count_ff + CW'(1);
               top_in   = need[32:0];
               res_in.result_address = app_addr;
               if (resize_ff) begin
                  res_in.copy_length = old_size_ff;
                  state_in           = S_FREE_OLD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_FREE_OLD: begin
            wr_en    = 1'b1;
            wr_addr  = old_idx_ff;
            wr_entry = '{blk_start: req_ff.block_address, blk_size: old_size_ff,
                         blk_free: 1'b1};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         top_ff   <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      prod_ff     <= prod_in;
      size_ff     <= size_in;
      grab_ff     <= grab_in;
      resize_ff   <= resize_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      old_idx_ff  <= old_idx_in;
      old_size_ff <= old_size_in;
      res_ff      <= res_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_RESP);
   assign result    = res_ff;

endmodule

/* rtl/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: register port, output stage
// and the command sequencer. Depends on ffba_pkg and ffba_engine.
`timescale 1ns / 1ps

// The allocator keeps a table of up to MAX_BLOCKS heap blocks in a single
// RAM, in the order they were appended, and serves one item at a time. An
// item that needs no table access (zero size, array overflow, release of
// address 0) goes from the size and decode steps straight to the result.
// Any other item scans the table one entry per cycle through the RAM read
// port, whose read is registered: the size is formed, the command is
// decoded, the table is scanned and updated where needed, and the result is
// handed over before the sequencer returns to idle. A resize that has to
// move scans twice and frees its old block once the new one is taken. A
// stalled result channel holds the result in the sequencer while the output
// register is still occupied. The next item is accepted as soon as the
// result has moved to the output register, even while it waits to be taken.
// Blocks are never split or merged, and data zeroing and copying are left to
// the user, who gets the number of bytes to copy after a moving resize. The
// table needs no clearing after reset: only entries below the block count
// are ever read. heap_base sits at byte address 0 and heap_limit at 4; both
// should be written only while the block is idle.

module first_fit_block_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ffba_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ffba_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [31:0]            heap_base_ff, heap_limit_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type      rsp_ff;
   ffba_pkg::cfg_type      cfg;
   ffba_pkg::eng_stat_type stat;
   ffba_pkg::rsp_type      eng_result;
   logic                   out_free;
   logic                   req_take;

   // Register port. Writes complete in the access phase; there are no wait
   // states.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= 32'd0;
         heap_limit_ff <= 32'd1048576;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            ffba_pkg::REG_HEAP_BASE:  heap_base_ff  <= pwdata;
            ffba_pkg::REG_HEAP_LIMIT: heap_limit_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ffba_pkg::REG_HEAP_BASE:  prdata = heap_base_ff;
         ffba_pkg::REG_HEAP_LIMIT: prdata = heap_limit_ff;
         default:                  prdata = 32'd0;
      endcase
   end

   assign cfg.heap_base  = heap_base_ff;
   assign cfg.heap_limit = heap_limit_ff;

   // The sequencer takes a new item only when it is idle.
   assign req_ready = stat.idle;
   assign req_take  = req_valid && req_ready;

   // The output register is free when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   ffba_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_take),
      .req      (req_payload),
      .cfg      (cfg),
      .out_free (out_free),
      .stat     (stat),
      .result   (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stat.done && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done && out_free) begin
         rsp_ff <= eng_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // Once an item is taken, the sequencer is busy in the next cycle.
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("allocator took an item while busy");

   // A finished result stays pending until the output register takes it.
   a_done_held : assert property (@(posedge clock) disable iff (reset)
      (stat.done && !out_free) |=> stat.done)
      else $error("finished result dropped before output was free");

   // A failed item never hands out an address or a copy length.
   a_fail_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != ffba_pkg::ST_OK)) |->
      ((rsp_payload.result_address == 32'd0) && (rsp_payload.copy_length == 32'd0)))
      else $error("failed item carries an address or copy length");

   // A result is loaded only from the finishing state of the sequencer.
   a_load_from_done : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> stat.done)
      else $error("output loaded without a finished result");
`endif

endmodule

/* sim/ffba_response_checker.sv */
// Result checker of the first-fit block allocator: keeps its own block table,
// predicts the result of every accepted item and compares it field by field.
// Depends on ffba_pkg for the payload types, codes and sizing constants.
`timescale 1ns / 1ps

module ffba_response_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  ffba_pkg::req_type               req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  ffba_pkg::rsp_type               rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output int                              mismatches,
   output int                              compared,
   output int                              outstanding
);

   // Shadow of the allocator state and its two registers.
   ffba_pkg::entry_type blocks [ffba_pkg::MAX_BLOCKS];
   int                  block_count;
   logic [63:0]         claimed_bytes;
   logic [31:0]         cfg_base;
   logic [31:0]         cfg_limit;

   ffba_pkg::rsp_type   pending_results [$];

   initial begin
      mismatches  = 0;
      compared    = 0;
      outstanding = 0;
   end

   // Takes the first free block that is large enough, else appends one at the
   // heap top, unless the table is full or the heap limit would be passed.
   function automatic logic [2:0] claim_block(input logic [31:0] size,
                                              output logic [31:0] addr);
      logic [63:0] need;
      addr = '0;
      for (int i = 0; i < block_count; i++) begin
         if (blocks[i].blk_free && blocks[i].blk_size >= size) begin
            blocks[i].blk_free = 1'b0;
            addr = blocks[i].blk_start;
            return ffba_pkg::ST_OK;
         end
      end
      if (block_count >= ffba_pkg::MAX_BLOCKS) return ffba_pkg::ST_NOSPACE;
      need = claimed_bytes + 64'(ffba_pkg::HEADER_BYTES) + 64'(size);
      if (need > 64'(cfg_limit)) return ffba_pkg::ST_NOSPACE;
      addr = 32'(64'(cfg_base) + claimed_bytes + 64'(ffba_pkg::HEADER_BYTES));
      blocks[block_count].blk_start = addr;
      blocks[block_count].blk_size  = size;
      blocks[block_count].blk_free  = 1'b0;
      block_count++;
      claimed_bytes = need;
      return ffba_pkg::ST_OK;
   endfunction

   function automatic int find_block(input logic [31:0] addr);
      for (int i = 0; i < block_count; i++)
         if (blocks[i].blk_start == addr) return i;
      return -1;
   endfunction

   function automatic ffba_pkg::rsp_type predict_response(input ffba_pkg::req_type r);
      logic [1:0]        cmd;
      logic [31:0]       size;
      logic [31:0]       addr;
      logic [31:0]       copy;
      logic [2:0]        status;
      logic [63:0]       product;
      int                idx;
      ffba_pkg::rsp_type res;
      cmd    = r.command;
      size   = r.request_size;
      addr   = '0;
      copy   = '0;
      status = ffba_pkg::ST_OK;
      if (cmd == ffba_pkg::CMD_ARRAY) begin
         product = 64'(r.element_count) * 64'(r.element_bytes);
         if (product > 64'h0000_0000_FFFF_FFFF) begin
            status = ffba_pkg::ST_NOSPACE;
         end else begin
            size = product[31:0];
            cmd  = ffba_pkg::CMD_ALLOC;
         end
      end else if (cmd == ffba_pkg::CMD_RESIZE && r.block_address == '0) begin
         cmd = ffba_pkg::CMD_ALLOC;
      end
      if (status == ffba_pkg::ST_OK) begin
         case (cmd)
            ffba_pkg::CMD_ALLOC: begin
               if (size == '0) status = ffba_pkg::ST_ZERO;
               else status = claim_block(size, addr);
            end
            ffba_pkg::CMD_RESIZE: begin
               idx = find_block(r.block_address);
               if (idx < 0) begin
                  status = ffba_pkg::ST_UNKNOWN;
               end else if (blocks[idx].blk_free) begin
                  status = ffba_pkg::ST_FREED;
               end else if (blocks[idx].blk_size >= size) begin
                  addr = r.block_address;
               end else begin
                  status = claim_block(size, addr);
                  if (status == ffba_pkg::ST_OK) begin
                     copy = blocks[idx].blk_size;
                     blocks[idx].blk_free = 1'b1;
                  end
               end
            end
            ffba_pkg::CMD_RELEASE: begin
               if (r.block_address != '0) begin
                  idx = find_block(r.block_address);
                  if (idx < 0) status = ffba_pkg::ST_UNKNOWN;
                  else if (blocks[idx].blk_free) status = ffba_pkg::ST_FREED;
                  else blocks[idx].blk_free = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (status != ffba_pkg::ST_OK) addr = '0;
      res.result_address = addr;
      res.status         = status;
      res.copy_length    = copy;
      return res;
   endfunction

   always @(posedge clock) begin
      ffba_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++) blocks[i] = '0;
         block_count   = 0;
         claimed_bytes = '0;
         cfg_base      = '0;
         cfg_limit     = 32'd1048576;
         pending_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {ffba_pkg::REG_HEAP_BASE, 2'b00}) cfg_base = pwdata;
            else if (paddr == {ffba_pkg::REG_HEAP_LIMIT, 2'b00}) cfg_limit = pwdata;
         end
         // A result leaving now belongs to an item accepted earlier, so it is
         // matched before this edge's item is predicted.
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result with no item waiting: address %h status %0d copy %h",
                      rsp_payload.result_address, rsp_payload.status,
                      rsp_payload.copy_length);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               compared++;
               if (rsp_payload.result_address !== want.result_address) begin
                  $error("result_address: expected %h, got %h",
                         want.result_address, rsp_payload.result_address);
                  mismatches++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  mismatches++;
               end
               if (rsp_payload.copy_length !== want.copy_length) begin
                  $error("copy_length: expected %h, got %h",
                         want.copy_length, rsp_payload.copy_length);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) pending_results.push_back(predict_response(req_payload));
      end
      outstanding <= pending_results.size();
   end

endmodule

/* sim/tb_first_fit_block_allocator.sv */
// Top of the allocator testbench: clock, reset, stimulus, register writes and
// the verdict. Depends on ffba_pkg, first_fit_block_allocator and the checker.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;

   // The block serves one item at a time and scans its table once, or twice
   // for a moving resize. The settle time and the watchdog are sized from
   // that.
   localparam int SETTLE_CYCLES  = 160;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 153;

   localparam logic [ffba_pkg::CSR_ADDR_W-1:0] ADDR_HEAP_BASE  =
      {ffba_pkg::REG_HEAP_BASE, 2'b00};
   localparam logic [ffba_pkg::CSR_ADDR_W-1:0] ADDR_HEAP_LIMIT =
      {ffba_pkg::REG_HEAP_LIMIT, 2'b00};

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   ffba_pkg::req_type               req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   ffba_pkg::rsp_type               rsp_payload;
   logic                            psel        = 1'b0;
   logic                            penable     = 1'b0;
   logic                            pwrite      = 1'b0;
   logic [ffba_pkg::CSR_ADDR_W-1:0] paddr       = '0;
   logic [31:0]                     pwdata      = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   int mismatches;
   int compared;
   int outstanding;
   int items_sent   = 0;
   int config_writes = 0;
   int quiet_cycles = 0;

   // While calm is set neither side inserts gaps, so the block also sees
   // long stretches of back-to-back items.
   bit calm = 1'b0;

   // Payload addresses the block has handed out; resizes and releases draw
   // most of their addresses from here so they reach real table entries.
   logic [31:0] handed_out [$];

   first_fit_block_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   ffba_response_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .compared    (compared),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 88) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Sizes lean small so that released blocks are often reused, with zero,
   // huge and all-ones sizes mixed in for the refusal paths.
   function automatic logic [31:0] random_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return '0;
      if (p < 60) return $urandom_range(1, 32);
      if (p < 85) return $urandom_range(33, 256);
      if (p < 93) return $urandom_range(257, 4096);
      if (p < 97) return $urandom;
      return 32'hFFFF_FFFF;
   endfunction

   // Array factors: small products mostly, full-width ones overflow.
   function automatic logic [31:0] random_factor();
      int p;
      p = $urandom_range(0, 99);
      if (p < 5) return '0;
      if (p < 75) return $urandom_range(1, 16);
      if (p < 90) return $urandom_range(17, 1024);
      return $urandom;
   endfunction

   function automatic logic [31:0] random_address();
      int          p;
      logic [31:0] a;
      p = $urandom_range(0, 99);
      if (handed_out.size() == 0 || p < 8) return $urandom;
      if (p < 14) return '0;
      a = handed_out[$urandom_range(0, handed_out.size() - 1)];
      // A near miss exercises the lookup failure next to a real entry.
      if (p < 20) return a + $urandom_range(1, 4);
      return a;
   endfunction

   function automatic ffba_pkg::req_type random_item();
      ffba_pkg::req_type r;
      int                p;
      // Fields the command does not use still carry random bits.
      r.command       = ffba_pkg::CMD_ALLOC;
      r.request_size  = $urandom;
      r.element_count = $urandom;
      r.element_bytes = $urandom;
      r.block_address = $urandom;
      p = $urandom_range(0, 99);
      if (p < 28) begin
         r.request_size = random_size();
      end else if (p < 38) begin
         r.command       = ffba_pkg::CMD_ARRAY;
         r.element_count = random_factor();
         r.element_bytes = random_factor();
      end else if (p < 65) begin
         r.command       = ffba_pkg::CMD_RESIZE;
         r.request_size  = random_size();
         r.block_address = random_address();
      end else begin
         r.command       = ffba_pkg::CMD_RELEASE;
         r.block_address = random_address();
      end
      return r;
   endfunction

   // Presents one item and returns at the edge where it is accepted. Valid is
   // only lowered when a gap follows, so back-to-back items keep it high.
   task automatic send_item(input ffba_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] size,
                           input logic [31:0] count, input logic [31:0] each,
                           input logic [31:0] addr);
      ffba_pkg::req_type r;
      r.command       = cmd;
      r.request_size  = size;
      r.element_count = count;
      r.element_bytes = each;
      r.block_address = addr;
      send_item(r);
   endtask

   // Stops sending and waits until every expected result has been taken,
   // then lets the block settle so that registers may be written.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the
   // edge where the access phase completes.
   task automatic csr_write(input logic [ffba_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      config_writes++;
      @(posedge clock);
   endtask

   // Register settings of one random phase; the extremes come round again
   // and again, with random values between them.
   task automatic configure_phase(input int phase);
      logic [31:0] base;
      logic [31:0] limit;
      case (phase % 4)
         0:       base = '0;
         1:       base = $urandom;
         2:       base = 32'hFFFF_FFFF;
         default: base = 32'hFFFF_FF00;
      endcase
      case (phase % 5)
         0:       limit = 32'h0010_0000;
         1:       limit = 32'hFFFF_FFFF;
         2:       limit = '0;
         3:       limit = $urandom_range(2000, 20000);
         default: limit = $urandom;
      endcase
      csr_write(ADDR_HEAP_BASE, base);
      csr_write(ADDR_HEAP_LIMIT, limit);
   endtask

   // The result side stalls at random, except in calm stretches.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Signals only move at rising edges, so at the falling edge a handshake
   // that completes at the next rising edge is already settled.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_payload.result_address != '0) begin
         if (handed_out.size() >= 96) handed_out.delete($urandom_range(0, 95));
         handed_out.push_back(rsp_payload.result_address);
      end
   end

   // Watchdog: any accepted item, delivered result or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d results still expected.",
                     WATCHDOG_LIMIT, outstanding);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, from reset with base 0 and the default limit. The
      // addresses below follow from a 24-byte header in front of each block.
      send_cmd(ffba_pkg::CMD_ALLOC,   32'd0, '0, '0, '0);            // zero size
      send_cmd(ffba_pkg::CMD_ARRAY,   '0, 32'd0, 32'd5, '0);         // zero-size array
      send_cmd(ffba_pkg::CMD_ARRAY,   '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0); // overflow
      send_cmd(ffba_pkg::CMD_ARRAY,   '0, 32'h0001_0000, 32'h0001_0000, '0); // exactly 2^32
      send_cmd(ffba_pkg::CMD_ARRAY,   '0, 32'h0001_0000, 32'h0000_FFFF, '0); // not in heap
      send_cmd(ffba_pkg::CMD_ALLOC,   32'hFFFF_FFFF, '0, '0, '0);    // past the heap limit
      send_cmd(ffba_pkg::CMD_ALLOC,   32'd16, '0, '0, '0);           // block at 24
      send_cmd(ffba_pkg::CMD_ARRAY,   '0, 32'd4, 32'd8, '0);         // block at 64
      send_cmd(ffba_pkg::CMD_RELEASE, '0, '0, '0, 32'd0);            // release of none
      send_cmd(ffba_pkg::CMD_RELEASE, '0, '0, '0, 32'd12345);        // unknown address
      send_cmd(ffba_pkg::CMD_RESIZE,  32'd8, '0, '0, 32'd0);         // none: block at 120
      send_cmd(ffba_pkg::CMD_RESIZE,  32'd0, '0, '0, 32'd24);        // fits with size zero
      send_cmd(ffba_pkg::CMD_RESIZE,  32'd16, '0, '0, 32'd24);       // fits exactly
      send_cmd(ffba_pkg::CMD_RESIZE,  32'd100, '0, '0, 32'd24);      // moves to 152, copies 16
      send_cmd(ffba_pkg::CMD_RELEASE, '0, '0, '0, 32'd24);           // double free
      send_cmd(ffba_pkg::CMD_RESIZE,  32'd4, '0, '0, 32'd24);        // resize of a free block
      send_cmd(ffba_pkg::CMD_ALLOC,   32'd10, '0, '0, '0);           // first fit reuses 24
      send_cmd(ffba_pkg::CMD_RELEASE, '0, '0, '0, 32'hFFFF_FFFF);    // unknown, all ones
      drain();

      // The heap top now stands at 252: a limit of 280 leaves exactly one
      // header plus four bytes.
      csr_write(ADDR_HEAP_LIMIT, 32'd280);
      send_cmd(ffba_pkg::CMD_ALLOC,   32'd5, '0, '0, '0);            // one byte too many
      send_cmd(ffba_pkg::CMD_ALLOC,   32'd4, '0, '0, '0);            // exactly at the limit
      drain();

      // A base near the top of the address space makes payload addresses wrap.
      csr_write(ADDR_HEAP_BASE, 32'hFFFF_FFF0);
      csr_write(ADDR_HEAP_LIMIT, 32'hFFFF_FFFF);
      send_cmd(ffba_pkg::CMD_ALLOC,   32'hFFFF_FFFF, '0, '0, '0);    // overflows widest limit
      send_cmd(ffba_pkg::CMD_ALLOC,   32'd1, '0, '0, '0);            // wraps to 0x120
      send_cmd(ffba_pkg::CMD_RELEASE, '0, '0, '0, 32'd152);
      send_cmd(ffba_pkg::CMD_RESIZE,  32'd50, '0, '0, 32'h0000_0120); // moves into freed 152
      send_cmd(ffba_pkg::CMD_RESIZE,  32'hFFFF_FFF0, '0, '0, 32'd64); // moving resize fails
      drain();

      // Random part: each phase brings new register settings; the table
      // fills early on, after which the traffic lives on reuse of freed
      // blocks and on the refusals of a full table.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure_phase(phase);
         calm = (phase % 3 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
         drain();
         calm = 1'b0;
      end

      $display("Sent %0d items and compared %0d results over %0d register writes.",
               items_sent, compared, config_writes);
      $display("Covered directed refusals, wrap and limit edges, then random traffic.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_engine.sv
rtl/first_fit_block_allocator.sv
sim/ffba_response_checker.sv
sim/tb_first_fit_block_allocator.sv
